/* sv/mcce_pkg.sv */
// shared types and constants for the matrix chain cost evaluator
package mcce_pkg;

  localparam int DIM_BITS  = 12;
  localparam int COST_BITS = 63;
  localparam int PROD_BITS = 3 * DIM_BITS;

  typedef enum logic [1:0] {
    REQ_OPEN    = 2'd0,
    REQ_CLOSE   = 2'd1,
    REQ_OPERAND = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2,
    ERR_SATURATED = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [DIM_BITS-1:0] rows;
    logic [DIM_BITS-1:0] cols;
    logic                last;
  } req_t;

  typedef struct packed {
    logic [COST_BITS-1:0] total_cost;
    logic [DIM_BITS-1:0]  result_rows;
    logic [DIM_BITS-1:0]  result_cols;
    logic [1:0]           error;
  } rsp_t;

  // one stack entry: marker flag plus a dimension pair
  typedef struct packed {
    logic                mark;
    logic [DIM_BITS-1:0] rows;
    logic [DIM_BITS-1:0] cols;
  } entry_t;

  // push: take the entry from the neighbor nearer the top
  // pop: take the entry from the neighbor farther from the top
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic clear;
  } cu_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } cu_status_t;

endpackage

/* sv/mcce_cell.sv */
// one stack cell: holds an entry and shifts with its neighbors
module mcce_cell (
  input  logic               clk_i,
  input  mcce_pkg::cell_ctl_t ctl_i,
  input  mcce_pkg::entry_t   prev_i,
  input  mcce_pkg::entry_t   next_i,
  output mcce_pkg::entry_t   entry_o
);
  import mcce_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    priority if (ctl_i.push) begin
      entry_d = prev_i;
    end else if (ctl_i.pop) begin
      entry_d = next_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* sv/mcce_cost_unit.sv */
// two-stage product of three dimensions and saturating cost accumulator
module mcce_cost_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcce_pkg::cu_ctl_t             ctl_i,
  input  logic [mcce_pkg::DIM_BITS-1:0] lhs_rows_i,
  input  logic [mcce_pkg::DIM_BITS-1:0] lhs_cols_i,
  input  logic [mcce_pkg::DIM_BITS-1:0] rhs_cols_i,
  output logic [mcce_pkg::COST_BITS-1:0] cost_o,
  output mcce_pkg::cu_status_t          status_o
);
  import mcce_pkg::*;

  logic [2*DIM_BITS-1:0]  p1_q;
  logic [DIM_BITS-1:0]    rc_q;
  logic [PROD_BITS-1:0]   p2_q;
  logic                   v1_q, v2_q;
  logic [COST_BITS-1:0]   cost_q, cost_d;
  logic [COST_BITS:0]     sum;

  assign sum = {1'b0, cost_q} + (COST_BITS + 1)'(p2_q);

  always_comb begin
    cost_d = cost_q;
    if (ctl_i.clear) begin
      cost_d = '0;
    end else if (v2_q) begin
      cost_d = sum[COST_BITS] ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      p1_q <= (2 * DIM_BITS)'(lhs_rows_i) * (2 * DIM_BITS)'(lhs_cols_i);
      rc_q <= rhs_cols_i;
    end
    if (v1_q) begin
      p2_q <= PROD_BITS'(p1_q) * PROD_BITS'(rc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      cost_q <= '0;
    end else begin
      v1_q   <= ctl_i.start;
      v2_q   <= v1_q;
      cost_q <= cost_d;
    end
  end

  assign cost_o          = cost_q;
  assign status_o.done   = v2_q;
  assign status_o.sat    = v2_q & sum[COST_BITS];

endmodule

/* sv/matrix_chain_cost_evaluator.sv */
// top level: parenthesized matrix chain cost evaluator
//
// The input channel carries one symbol per transaction: open, close, or a
// matrix operand with rows and cols. Symbols are kept on a shift-register
// stack of STACK_DEPTH cells, the top in cell 0. A close reduces the top
// operand pairs one at a time through a two-stage multiplier.
// Open, operand and none symbols are handled as they are taken, in ST_IDLE; a
// close passes through ST_CLOSE and, for each reduced pair, through ST_WAIT
// until the multiplier pipeline reports the cost. A symbol with last set
// then passes through ST_FIN, which loads its result transaction into the
// output register once it is free. The output register holds the result
// while the receiver stalls; the block keeps taking symbols and only waits
// if a second result is ready before the first one has been taken.
// Reset empties the stack and clears the cost, the error code and the
// output valid; no clearing pass is needed. After each result the stack,
// cost and error code are cleared for the next expression.
module matrix_chain_cost_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mcce_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mcce_pkg::rsp_t  out_rsp_o
);
  import mcce_pkg::*;

  localparam int SP_BITS = $clog2(STACK_DEPTH + 1);

  state_e state_q, state_d;
  logic [SP_BITS-1:0] sp_q, sp_d;
  err_e err_q, err_d;
  logic last_q;
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  entry_t cells [STACK_DEPTH];
  logic push_en, pop_en, top_load;
  entry_t load_val;
  cu_ctl_t cu_ctl;
  cu_status_t cu_status;
  logic [COST_BITS-1:0] cost;
  logic accept, full, two_ops, out_free;
  entry_t top, second;

  assign top      = cells[0];
  assign second   = cells[1];
  assign accept   = in_valid_i & ~in_stall_o;
  assign full     = (sp_q == SP_BITS'(STACK_DEPTH));
  assign two_ops  = (sp_q > SP_BITS'(1)) & ~top.mark & ~second.mark;
  assign out_free = ~out_valid_q | ~out_stall_i;

  assign in_stall_o = (state_q != ST_IDLE);

  // stack chain
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    prev, next;
    if (i == 0) begin : g_top
      assign ctl.push = push_en | top_load;
      assign ctl.pop  = pop_en;
      assign prev     = load_val;
    end else begin : g_mid
      assign ctl.push = push_en;
      assign ctl.pop  = pop_en | top_load;
      assign prev     = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign next = '0;
    end else begin : g_link
      assign next = cells[i+1];
    end
    mcce_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .prev_i  (prev),
      .next_i  (next),
      .entry_o (cells[i])
    );
  end

  mcce_cost_unit u_cost (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (cu_ctl),
    .lhs_rows_i (second.rows),
    .lhs_cols_i (second.cols),
    .rhs_cols_i (top.cols),
    .cost_o     (cost),
    .status_o   (cu_status)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_e'(in_req_i.req_type) == REQ_CLOSE) begin
            state_d = ST_CLOSE;
          end else if (in_req_i.last) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_CLOSE: begin
        if (two_ops) begin
          state_d = ST_WAIT;
        end else if (last_q) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (cu_status.done) begin
          state_d = ST_CLOSE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    push_en     = 1'b0;
    pop_en      = 1'b0;
    top_load    = 1'b0;
    load_val    = '0;
    cu_ctl      = '0;
    sp_d        = sp_q;
    err_d       = err_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_e'(in_req_i.req_type))
            REQ_OPEN, REQ_OPERAND: begin
              if (full) begin
                if (err_q == ERR_NONE) err_d = ERR_OVERFLOW;
              end else begin
                push_en       = 1'b1;
                load_val.mark = (req_type_e'(in_req_i.req_type) == REQ_OPEN);
                load_val.rows = load_val.mark ? '0 : in_req_i.rows;
                load_val.cols = load_val.mark ? '0 : in_req_i.cols;
                sp_d          = sp_q + SP_BITS'(1);
              end
            end
            REQ_CLOSE, REQ_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLOSE: begin
        if (two_ops) begin
          // fold the top pair into one operand; cost follows in the unit
          cu_ctl.start  = 1'b1;
          top_load      = 1'b1;
          load_val.mark = 1'b0;
          load_val.rows = second.rows;
          load_val.cols = top.cols;
          sp_d          = sp_q - SP_BITS'(1);
        end else if (sp_q == '0) begin
          if (err_q == ERR_NONE) err_d = ERR_UNMATCHED;
        end else if (top.mark) begin
          pop_en = 1'b1;
          sp_d   = sp_q - SP_BITS'(1);
        end else if (sp_q == SP_BITS'(1)) begin
          if (err_q == ERR_NONE) err_d = ERR_UNMATCHED;
        end else begin
          // lone operand over its marker: the operand takes the marker's place
          top_load      = 1'b1;
          load_val.mark = 1'b0;
          load_val.rows = top.rows;
          load_val.cols = top.cols;
          sp_d          = sp_q - SP_BITS'(1);
        end
      end
      ST_WAIT: begin
        if (cu_status.sat && err_q == ERR_NONE) err_d = ERR_SATURATED;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.total_cost = cost;
          if (sp_q != '0 && !top.mark) begin
            out_d.result_rows = top.rows;
            out_d.result_cols = top.cols;
          end else begin
            out_d.result_rows = '0;
            out_d.result_cols = '0;
          end
          out_d.error  = err_q;
          sp_d         = '0;
          err_d        = ERR_NONE;
          cu_ctl.clear = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      err_q       <= ERR_NONE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        last_q <= in_req_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
